// ----- hw/rtl/jst_pkg.sv -----
// types, codes and literal tables shared by the scalar tokenizer
`timescale 1ns / 1ps
package jst_pkg;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STR  = 3'd1;
  localparam logic [2:0] MODE_ESC  = 3'd2;
  localparam logic [2:0] MODE_LIT  = 3'd3;
  localparam logic [2:0] MODE_INT  = 3'd4;

  localparam logic [2:0] KIND_CHAR = 3'd0;
  localparam logic [2:0] KIND_SEND = 3'd1;
  localparam logic [2:0] KIND_INT  = 3'd2;
  localparam logic [2:0] KIND_BOOL = 3'd3;
  localparam logic [2:0] KIND_NULL = 3'd4;
  localparam logic [2:0] KIND_ARR  = 3'd5;
  localparam logic [2:0] KIND_OBJ  = 3'd6;
  localparam logic [2:0] KIND_ERR  = 3'd7;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6c;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CODE_BS   = 8'd8;
  localparam logic [7:0] CODE_FF   = 8'd12;
  localparam logic [7:0] CODE_LF   = 8'd10;
  localparam logic [7:0] CODE_CR   = 8'd13;
  localparam logic [7:0] CODE_TAB  = 8'd9;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  lsel;
    logic [2:0]  lpos;
    logic [63:0] acc;
    logic        neg;
    logic        seen;
    logic        sat;
  } st_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         char_byte;
    logic signed [63:0] int_value;
    logic               bool_value;
    logic               last;
  } res_t;

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    logic [2:0] l;
    begin
      case (sel)
        LIT_TRUE:  l = 3'd4;
        LIT_FALSE: l = 3'd5;
        LIT_NULL:  l = 3'd4;
        default:   l = 3'd0;
      endcase
      return l;
    end
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] c;
    begin
      c = CH_NUL;
      case (sel)
        LIT_TRUE: begin
          case (pos)
            3'd0: c = CH_T;
            3'd1: c = CH_R;
            3'd2: c = CH_U;
            3'd3: c = CH_E;
            default: c = CH_NUL;
          endcase
        end
        LIT_FALSE: begin
          case (pos)
            3'd0: c = CH_F;
            3'd1: c = CH_A;
            3'd2: c = CH_L;
            3'd3: c = CH_S;
            3'd4: c = CH_E;
            default: c = CH_NUL;
          endcase
        end
        LIT_NULL: begin
          case (pos)
            3'd0: c = CH_N;
            3'd1: c = CH_U;
            3'd2: c = CH_L;
            3'd3: c = CH_L;
            default: c = CH_NUL;
          endcase
        end
        default: c = CH_NUL;
      endcase
      return c;
    end
  endfunction

endpackage

// ----- hw/rtl/json_scalar_tokenizer_unit.sv -----
// top level of the json scalar tokenizer
//
//   channel | direction | payload                                      | handshake
//   in_     | input     | in_byte[7:0]                                 | in_valid / in_ready
//   out_    | output    | kind, char_byte, int_value, bool_value, last | out_valid / out_ready
//
// one byte per cycle enters the input register while the queue has room and is decoded there
// results pass through a four-entry queue, so a byte with two results needs two
// pops; one byte per cycle is kept up while out_ready is high and no byte gives two results
// the input register holds while the queue has fewer than two free entries
// synchronous active-low reset returns the tokenizer to idle with an empty queue
`timescale 1ns / 1ps
module json_scalar_tokenizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_char_byte,
  output logic signed [63:0] out_int_value,
  output logic               out_bool_value,
  output logic               out_last
);
  import jst_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  st_t        st_r, st_nxt;
  res_t       res0, res1, head;
  logic [1:0] n_res;
  logic       room2;
  logic       proceed;

  assign proceed  = in_v_r && room2;
  assign in_ready = !in_v_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (proceed) begin
      st_r <= st_nxt;
    end
  end

  jst_step u_step (
    .in_byte (in_byte_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res0    (res0),
    .res1    (res1),
    .n_res   (n_res)
  );

  jst_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (proceed ? n_res : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind       = head.kind;
  assign out_char_byte  = head.char_byte;
  assign out_int_value  = head.int_value;
  assign out_bool_value = head.bool_value;
  assign out_last       = head.last;

endmodule

// ----- hw/rtl/jst_step.sv -----
// per-byte decode: next tokenizer state and up to two results
`timescale 1ns / 1ps
module jst_step (
  input  logic [7:0]    in_byte,
  input  jst_pkg::st_t  st,
  output jst_pkg::st_t  st_nxt,
  output jst_pkg::res_t res0,
  output jst_pkg::res_t res1,
  output logic [1:0]    n_res
);
  import jst_pkg::*;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    st_t        st;
  } fresh_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] ch,
                                  input logic [63:0] iv, input logic bv);
    res_t r;
    begin
      r.kind       = kind;
      r.char_byte  = ch;
      r.int_value  = iv;
      r.bool_value = bv;
      r.last       = 1'b0;
      return r;
    end
  endfunction

  function automatic fresh_t fresh(input logic [7:0] b, input st_t s);
    fresh_t f;
    begin
      f.st      = s;
      f.st.mode = MODE_IDLE;
      f.emit    = 1'b0;
      f.kind    = KIND_ERR;
      case (b) inside
        CH_QUOTE:  f.st.mode = MODE_STR;
        CH_LBRACK: begin
          f.emit = 1'b1;
          f.kind = KIND_ARR;
        end
        CH_LBRACE: begin
          f.emit = 1'b1;
          f.kind = KIND_OBJ;
        end
        CH_T, CH_F, CH_N: begin
          f.st.lsel = (b == CH_T) ? LIT_TRUE : ((b == CH_F) ? LIT_FALSE : LIT_NULL);
          f.st.lpos = 3'd1;
          f.st.mode = MODE_LIT;
        end
        CH_MINUS: begin
          f.st.mode = MODE_INT;
          f.st.acc  = 64'd0;
          f.st.neg  = 1'b1;
          f.st.seen = 1'b0;
          f.st.sat  = 1'b0;
        end
        default: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            f.st.mode = MODE_INT;
            f.st.acc  = {60'd0, b[3:0]};
            f.st.neg  = 1'b0;
            f.st.seen = 1'b1;
            f.st.sat  = 1'b0;
          end else begin
            f.emit = 1'b1;
          end
        end
      endcase
      return f;
    end
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] c;
    begin
      case (b)
        CH_B:    c = CODE_BS;
        CH_F:    c = CODE_FF;
        CH_N:    c = CODE_LF;
        CH_R:    c = CODE_CR;
        CH_T:    c = CODE_TAB;
        default: c = b;
      endcase
      return c;
    end
  endfunction

  fresh_t      fr;
  logic        is_digit;
  logic        lit_ok;
  logic [2:0]  pos_inc;
  logic [63:0] lim;
  logic [67:0] acc_x10;
  logic        over;
  logic [63:0] ival;

  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign lit_ok   = (st.lsel != 2'd3) && (st.lpos < lit_len(st.lsel)) &&
                    (in_byte == lit_char(st.lsel, st.lpos));
  assign pos_inc  = st.lpos + 3'd1;
  assign lim      = st.neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  assign acc_x10  = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {64'd0, in_byte[3:0]};
  assign over     = st.sat || (acc_x10 > {4'd0, lim});
  assign ival     = st.neg ? (64'd0 - st.acc) : st.acc;
  assign fr       = fresh(in_byte, st);

  always_comb begin
    st_nxt = st;
    res0   = mk_res(KIND_ERR, 8'd0, 64'd0, 1'b0);
    res1   = mk_res(KIND_ERR, 8'd0, 64'd0, 1'b0);
    n_res  = 2'd0;
    unique case (st.mode)
      MODE_STR: begin
        if (in_byte == CH_QUOTE) begin
          st_nxt.mode = MODE_IDLE;
          res0        = mk_res(KIND_SEND, 8'd0, 64'd0, 1'b0);
          n_res       = 2'd1;
        end else if (in_byte == CH_BSLASH) begin
          st_nxt.mode = MODE_ESC;
        end else if (in_byte == CH_NUL) begin
          st_nxt.mode = MODE_IDLE;
          n_res       = 2'd1;
        end else begin
          res0  = mk_res(KIND_CHAR, in_byte, 64'd0, 1'b0);
          n_res = 2'd1;
        end
      end
      MODE_ESC: begin
        n_res = 2'd1;
        if (in_byte == CH_NUL) begin
          st_nxt.mode = MODE_IDLE;
        end else begin
          st_nxt.mode = MODE_STR;
          res0        = mk_res(KIND_CHAR, unescape(in_byte), 64'd0, 1'b0);
        end
      end
      MODE_LIT: begin
        if (lit_ok) begin
          st_nxt.lpos = pos_inc;
          if (pos_inc == lit_len(st.lsel)) begin
            st_nxt.mode = MODE_IDLE;
            n_res       = 2'd1;
            if (st.lsel == LIT_NULL) begin
              res0 = mk_res(KIND_NULL, 8'd0, 64'd0, 1'b0);
            end else begin
              res0 = mk_res(KIND_BOOL, 8'd0, 64'd0, st.lsel == LIT_TRUE);
            end
          end
        end else begin
          st_nxt.mode = MODE_IDLE;
          n_res       = 2'd1;
        end
      end
      MODE_INT: begin
        if (is_digit) begin
          st_nxt.seen = 1'b1;
          if (over) begin
            st_nxt.acc = lim;
            st_nxt.sat = 1'b1;
          end else begin
            st_nxt.acc = acc_x10[63:0];
          end
        end else begin
          if (st.seen) begin
            res0 = mk_res(KIND_INT, 8'd0, ival, 1'b0);
          end
          st_nxt = fr.st;
          res1   = mk_res(fr.kind, 8'd0, 64'd0, 1'b0);
          n_res  = fr.emit ? 2'd2 : 2'd1;
        end
      end
      default: begin
        st_nxt = fr.st;
        res0   = mk_res(fr.kind, 8'd0, 64'd0, 1'b0);
        n_res  = fr.emit ? 2'd1 : 2'd0;
      end
    endcase
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

endmodule

// ----- hw/rtl/jst_outq.sv -----
// result queue: up to two pushes per cycle, one pop per transaction
`timescale 1ns / 1ps
module jst_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  jst_pkg::res_t push0,
  input  jst_pkg::res_t push1,
  output logic          room2,
  output logic          out_valid,
  input  logic          out_ready,
  output jst_pkg::res_t head
);
  import jst_pkg::*;

  res_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           pop;
  logic [QAW-1:0] wr_p1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign room2     = (cnt_r <= (QAW + 1)'(QDEPTH - 2));
  assign head      = q_r[rd_r];
  assign wr_p1     = wr_r + QAW'(1);
  assign wr_nxt    = wr_r + QAW'(push_n);
  assign rd_nxt    = pop ? rd_r + QAW'(1) : rd_r;
  assign cnt_nxt   = cnt_r + (QAW + 1)'(push_n) - (QAW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_p1] <= push1;
    end
  end

endmodule

// ----- hw/rtl/jst_checker.sv -----
// port-level checks for the json scalar tokenizer, bound to the top level
`timescale 1ns / 1ps
module jst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_kind,
  input logic [7:0]         out_char_byte,
  input logic signed [63:0] out_int_value,
  input logic               out_bool_value
);
  import jst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  a_int_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_INT |-> out_int_value == 64'sd0)
    else $error("integer field set on non-integer transaction");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CHAR |-> out_char_byte == 8'd0)
    else $error("byte field set on non-byte transaction");

  a_bool_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BOOL |-> !out_bool_value)
    else $error("boolean field set on non-boolean transaction");

endmodule

bind json_scalar_tokenizer_unit jst_checker u_jst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_char_byte  (out_char_byte),
  .out_int_value  (out_int_value),
  .out_bool_value (out_bool_value)
);

// ----- dv/json_scalar_tokenizer_unit_test.sv -----
// testbench for the json scalar tokenizer: directed table, random json text, own predictor
`timescale 1ns / 1ps
module json_scalar_tokenizer_unit_test;
  import jst_pkg::*;

  typedef struct {
    logic [7:0] text;
    logic       typed;
    res_t       tok;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_kind;
  logic [7:0]         out_char_byte;
  logic signed [63:0] out_int_value;
  logic               out_bool_value;
  logic               out_last;

  int        in_idle_pct = 0;
  int        out_idle_pct = 0;
  int        mismatch_count = 0;
  logic      hold_req = 1'b0;
  res_t      expected_tokens[$];
  res_t      step_out[$];
  logic [7:0] text_bytes[$];
  stim_row_t directed_rows[$];

  // predictor state
  logic [2:0]  tok_mode = MODE_IDLE;
  logic [1:0]  word_sel = LIT_TRUE;
  logic [2:0]  word_pos = 3'd0;
  logic [63:0] magnitude = 64'd0;
  logic        int_negative = 1'b0;
  logic        digit_seen = 1'b0;
  logic        clamped = 1'b0;

  json_scalar_tokenizer_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_char_byte (out_char_byte),
    .out_int_value (out_int_value),
    .out_bool_value(out_bool_value),
    .out_last      (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic res_t make_tok(input logic [2:0] kind, input logic [7:0] ch,
                                    input logic [63:0] iv, input logic bv, input logic fin);
    res_t r;
    r.kind = kind;
    r.char_byte = ch;
    r.int_value = iv;
    r.bool_value = bv;
    r.last = fin;
    return r;
  endfunction

  function automatic void emit(input logic [2:0] kind, input logic [7:0] ch,
                               input logic [63:0] iv, input logic bv);
    step_out.push_back(make_tok(kind, ch, iv, bv, 1'b0));
  endfunction

  function automatic logic [7:0] word_byte(input logic [1:0] sel, input logic [2:0] pos);
    logic [39:0] w;
    case (sel)
      LIT_TRUE:  w = {CH_T, CH_R, CH_U, CH_E, CH_NUL};
      LIT_FALSE: w = {CH_F, CH_A, CH_L, CH_S, CH_E};
      LIT_NULL:  w = {CH_N, CH_U, CH_L, CH_L, CH_NUL};
      default:   w = '0;
    endcase
    if (pos > 3'd4) return CH_NUL;
    return w[8 * (4 - pos) +: 8];
  endfunction

  function automatic int word_len(input logic [1:0] sel);
    if (sel == LIT_FALSE) return 5;
    if (sel == LIT_TRUE || sel == LIT_NULL) return 4;
    return 0;
  endfunction

  function automatic logic [7:0] unescape_byte(input logic [7:0] b);
    case (b)
      CH_B:    return CODE_BS;
      CH_F:    return CODE_FF;
      CH_N:    return CODE_LF;
      CH_R:    return CODE_CR;
      CH_T:    return CODE_TAB;
      default: return b;
    endcase
  endfunction

  function automatic void start_value(input logic [7:0] b);
    tok_mode = MODE_IDLE;
    if (b == CH_QUOTE) begin
      tok_mode = MODE_STR;
    end else if (b == CH_LBRACK) begin
      emit(KIND_ARR, 8'h00, 64'd0, 1'b0);
    end else if (b == CH_LBRACE) begin
      emit(KIND_OBJ, 8'h00, 64'd0, 1'b0);
    end else if (b == CH_T || b == CH_F || b == CH_N) begin
      word_sel = (b == CH_T) ? LIT_TRUE : ((b == CH_F) ? LIT_FALSE : LIT_NULL);
      word_pos = 3'd1;
      tok_mode = MODE_LIT;
    end else if (b == CH_MINUS) begin
      tok_mode = MODE_INT;
      magnitude = 64'd0;
      int_negative = 1'b1;
      digit_seen = 1'b0;
      clamped = 1'b0;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      tok_mode = MODE_INT;
      magnitude = {56'd0, b - CH_ZERO};
      int_negative = 1'b0;
      digit_seen = 1'b1;
      clamped = 1'b0;
    end else begin
      emit(KIND_ERR, 8'h00, 64'd0, 1'b0);
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b);
    logic [63:0] digit;
    logic [63:0] ceiling;
    step_out.delete();
    case (tok_mode)
      MODE_STR: begin
        if (b == CH_QUOTE) begin
          tok_mode = MODE_IDLE;
          emit(KIND_SEND, 8'h00, 64'd0, 1'b0);
        end else if (b == CH_BSLASH) begin
          tok_mode = MODE_ESC;
        end else if (b == CH_NUL) begin
          tok_mode = MODE_IDLE;
          emit(KIND_ERR, 8'h00, 64'd0, 1'b0);
        end else begin
          emit(KIND_CHAR, b, 64'd0, 1'b0);
        end
      end
      MODE_ESC: begin
        if (b == CH_NUL) begin
          tok_mode = MODE_IDLE;
          emit(KIND_ERR, 8'h00, 64'd0, 1'b0);
        end else begin
          tok_mode = MODE_STR;
          emit(KIND_CHAR, unescape_byte(b), 64'd0, 1'b0);
        end
      end
      MODE_LIT: begin
        if (int'(word_pos) < word_len(word_sel) && b == word_byte(word_sel, word_pos)) begin
          word_pos = word_pos + 3'd1;
          if (int'(word_pos) == word_len(word_sel)) begin
            tok_mode = MODE_IDLE;
            if (word_sel == LIT_NULL) emit(KIND_NULL, 8'h00, 64'd0, 1'b0);
            else emit(KIND_BOOL, 8'h00, 64'd0, word_sel == LIT_TRUE);
          end
        end else begin
          tok_mode = MODE_IDLE;
          emit(KIND_ERR, 8'h00, 64'd0, 1'b0);
        end
      end
      MODE_INT: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          digit = {56'd0, b - CH_ZERO};
          ceiling = int_negative ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
          digit_seen = 1'b1;
          if (clamped || magnitude > (ceiling - digit) / 64'd10) begin
            magnitude = ceiling;
            clamped = 1'b1;
          end else begin
            magnitude = magnitude * 64'd10 + digit;
          end
        end else begin
          if (digit_seen) emit(KIND_INT, 8'h00, int_negative ? -magnitude : magnitude, 1'b0);
          else emit(KIND_ERR, 8'h00, 64'd0, 1'b0);
          start_value(b);
        end
      end
      default: start_value(b);
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_token(input res_t got);
    res_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("unexpected transaction, kind", 64'(got.kind), 64'd0);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", 64'(got.kind), 64'(want.kind));
    if (got.char_byte !== want.char_byte) report_mismatch("char_byte", 64'(got.char_byte),
                                                          64'(want.char_byte));
    if (got.int_value !== want.int_value) report_mismatch("int_value", got.int_value,
                                                          want.int_value);
    if (got.bool_value !== want.bool_value) report_mismatch("bool_value", 64'(got.bool_value),
                                                            64'(want.bool_value));
    if (got.last !== want.last) report_mismatch("last", 64'(got.last), 64'(want.last));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed, input res_t typed_tok);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(b);
    if (typed) expected_tokens.push_back(typed_tok);
    else foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
  endtask

  task automatic add_row(input logic [7:0] b, input logic typed, input logic [2:0] kind,
                         input logic [7:0] ch);
    stim_row_t row;
    row.text = b;
    row.typed = typed;
    row.tok = make_tok(kind, ch, 64'd0, 1'b0, 1'b1);
    directed_rows.push_back(row);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) text_bytes.push_back(s[i]);
  endtask

  task automatic add_separator();
    case ($urandom_range(5))
      0: push_text(" ");
      1: push_text(",");
      2: push_text(":");
      3: text_bytes.push_back(CODE_LF);
      4: push_text("]");
      default: push_text("}");
    endcase
  endtask

  task automatic add_string();
    int len;
    int r;
    logic [7:0] c;
    text_bytes.push_back(CH_QUOTE);
    len = $urandom_range(8);
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 15) begin
        text_bytes.push_back(CH_BSLASH);
        if ($urandom_range(99) < 60) begin
          case ($urandom_range(4))
            0: text_bytes.push_back(CH_B);
            1: text_bytes.push_back(CH_F);
            2: text_bytes.push_back(CH_N);
            3: text_bytes.push_back(CH_R);
            default: text_bytes.push_back(CH_T);
          endcase
        end else begin
          text_bytes.push_back(8'($urandom_range(255)));
        end
      end else if (r < 18) begin
        text_bytes.push_back(CH_NUL);
      end else begin
        if (r < 70) c = 8'($urandom_range(8'h7e, 8'h20));
        else c = 8'($urandom_range(255, 1));
        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_A;
        text_bytes.push_back(c);
      end
    end
    if ($urandom_range(99) < 90) text_bytes.push_back(CH_QUOTE);
  endtask

  task automatic add_literal();
    logic [1:0] sel;
    int len;
    int cut;
    sel = 2'($urandom_range(2));
    len = word_len(sel);
    cut = ($urandom_range(99) < 80) ? len : $urandom_range(len - 1, 1);
    for (int i = 0; i < cut; i++) text_bytes.push_back(word_byte(sel, 3'(i)));
    if (cut < len) text_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_integer();
    int r;
    int len;
    if ($urandom_range(1)) text_bytes.push_back(CH_MINUS);
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(3))
        0: push_text("9223372036854775807");
        1: push_text("9223372036854775808");
        2: push_text("9223372036854775809");
        default: push_text("99999999999999999999999");
      endcase
    end else if (r < 20) begin
      len = 0;
    end else begin
      len = (r < 70) ? $urandom_range(4, 1) : $urandom_range(22, 1);
      repeat (len) text_bytes.push_back(8'($urandom_range(CH_NINE, CH_ZERO)));
    end
    if ($urandom_range(99) < 70) add_separator();
  endtask

  task automatic make_random_text(input int n_bytes);
    int pick;
    text_bytes.delete();
    while (text_bytes.size() < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 25) add_string();
      else if (pick < 40) add_literal();
      else if (pick < 65) add_integer();
      else if (pick < 75) text_bytes.push_back($urandom_range(1) ? CH_LBRACK : CH_LBRACE);
      else if (pick < 88) add_separator();
      else text_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin : result_sink
    int   hold_left;
    logic hold_taken;
    res_t got;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.kind = out_kind;
        got.char_byte = out_char_byte;
        got.int_value = out_int_value;
        got.bool_value = out_bool_value;
        got.last = out_last;
        check_token(got);
      end
      if (hold_req && !hold_taken) begin
        hold_left = 300;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin : byte_source
    res_t no_tok;
    no_tok = make_tok(KIND_CHAR, 8'h00, 64'd0, 1'b0, 1'b0);

    add_row(" ",       1'b1, KIND_ERR,  8'h00);
    add_row(8'hff,     1'b1, KIND_ERR,  8'h00);
    add_row(CH_LBRACK, 1'b1, KIND_ARR,  8'h00);
    add_row(CH_LBRACE, 1'b1, KIND_OBJ,  8'h00);
    add_row(CH_QUOTE,  1'b0, KIND_CHAR, 8'h00);
    add_row(8'h01,     1'b1, KIND_CHAR, 8'h01);
    add_row(8'hff,     1'b1, KIND_CHAR, 8'hff);
    add_row(CH_BSLASH, 1'b0, KIND_CHAR, 8'h00);
    add_row(CH_F,      1'b0, KIND_CHAR, 8'h00);
    add_row(CH_QUOTE,  1'b1, KIND_SEND, 8'h00);
    add_row(CH_QUOTE,  1'b0, KIND_CHAR, 8'h00);
    add_row(CH_BSLASH, 1'b0, KIND_CHAR, 8'h00);
    add_row(CH_NUL,    1'b1, KIND_ERR,  8'h00);
    add_row(CH_QUOTE,  1'b0, KIND_CHAR, 8'h00);
    add_row(CH_NUL,    1'b1, KIND_ERR,  8'h00);
    add_row(CH_N,      1'b0, KIND_CHAR, 8'h00);
    add_row("x",       1'b1, KIND_ERR,  8'h00);
    add_row(CH_MINUS,  1'b0, KIND_CHAR, 8'h00);
    add_row(",",       1'b0, KIND_CHAR, 8'h00);
    add_row("0",       1'b0, KIND_CHAR, 8'h00);
    add_row("7",       1'b0, KIND_CHAR, 8'h00);
    add_row("]",       1'b0, KIND_CHAR, 8'h00);
    add_row(CH_T,      1'b0, KIND_CHAR, 8'h00);
    add_row(CH_R,      1'b0, KIND_CHAR, 8'h00);
    add_row("x",       1'b1, KIND_ERR,  8'h00);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 17 : ((phase == 1) ? 65 : 0);
      out_idle_pct = (phase == 0) ? 65 : ((phase == 1) ? 17 : 0);
      if (phase == 0) begin
        foreach (directed_rows[i])
          send_byte(directed_rows[i].text, directed_rows[i].typed, directed_rows[i].tok);
      end
      // long receiver stall while bytes keep coming
      if (phase == 2) hold_req = 1'b1;
      make_random_text(350);
      foreach (text_bytes[i]) send_byte(text_bytes[i], 1'b0, no_tok);
    end
    in_valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/jst_pkg.sv
hw/rtl/jst_step.sv
hw/rtl/jst_outq.sv
hw/rtl/json_scalar_tokenizer_unit.sv
hw/rtl/jst_checker.sv
dv/json_scalar_tokenizer_unit_test.sv
